### rtl/akt_pkg.sv
package akt_pkg;

    localparam int GAIN_W     = 24;
    localparam int GAIN_SHIFT = 16;
    localparam int DIST_W     = 17;
    localparam int HYST_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        MODE_DIGITAL = 2'd0,
        MODE_THRESH  = 2'd1,
        MODE_RAPID   = 2'd2,
        MODE_SPEED   = 2'd3
    } key_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_MODE    = 3'd0,
        REG_TOP_LEVEL   = 3'd1,
        REG_TRAVEL_GAIN = 3'd2,
        REG_PRESS_DIST  = 3'd3,
        REG_LIFT_DIST   = 3'd4,
        REG_HYSTERESIS  = 3'd5,
        REG_PRESS_RATE  = 3'd6,
        REG_LIFT_RATE   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        key_mode_t                 key_mode;
        logic [GAIN_W-1:0]         travel_gain;
        logic signed [DIST_W-1:0]  press_dist;
        logic signed [DIST_W-1:0]  lift_dist;
        logic [HYST_W-1:0]         hysteresis;
        logic signed [DIST_W-1:0]  press_rate;
        logic signed [DIST_W-1:0]  lift_rate;
    } akt_cfg_t;

    // request fields carried alongside the normalized travel
    typedef struct packed {
        logic req_type;
        logic forced_state;
        logic raw_nonzero;
    } akt_item_t;

    localparam logic [GAIN_W-1:0]        RST_TRAVEL_GAIN = 24'd65536;
    localparam logic signed [DIST_W-1:0] RST_PRESS_DIST  = 17'sd16384;
    localparam logic signed [DIST_W-1:0] RST_LIFT_DIST   = 17'sd3277;
    localparam logic [HYST_W-1:0]        RST_HYSTERESIS  = 16'd1638;
    localparam logic signed [DIST_W-1:0] RST_PRESS_RATE  = 17'sd1638;
    localparam logic signed [DIST_W-1:0] RST_LIFT_RATE   = -17'sd1638;

endpackage

### rtl/akt_cfg.sv
module akt_cfg #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [akt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [akt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output akt_pkg::akt_cfg_t                 cfg,
    output logic [SAMPLE_BITS-1:0]            top_level
);
    import akt_pkg::*;

    akt_cfg_t               cfg_reg;
    logic [SAMPLE_BITS-1:0] top_level_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign top_level = top_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.key_mode    <= MODE_DIGITAL;
            cfg_reg.travel_gain <= RST_TRAVEL_GAIN;
            cfg_reg.press_dist  <= RST_PRESS_DIST;
            cfg_reg.lift_dist   <= RST_LIFT_DIST;
            cfg_reg.hysteresis  <= RST_HYSTERESIS;
            cfg_reg.press_rate  <= RST_PRESS_RATE;
            cfg_reg.lift_rate   <= RST_LIFT_RATE;
            top_level_reg       <= {SAMPLE_BITS{1'b1}};
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                REG_KEY_MODE:    cfg_reg.key_mode <= key_mode_t'(cfg_wdata[1:0]);
                REG_TOP_LEVEL:   top_level_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_TRAVEL_GAIN: cfg_reg.travel_gain <= cfg_wdata[GAIN_W-1:0];
                REG_PRESS_DIST:  cfg_reg.press_dist <= $signed(cfg_wdata[DIST_W-1:0]);
                REG_LIFT_DIST:   cfg_reg.lift_dist <= $signed(cfg_wdata[DIST_W-1:0]);
                REG_HYSTERESIS:  cfg_reg.hysteresis <= cfg_wdata[HYST_W-1:0];
                REG_PRESS_RATE:  cfg_reg.press_rate <= $signed(cfg_wdata[DIST_W-1:0]);
                REG_LIFT_RATE:   cfg_reg.lift_rate <= $signed(cfg_wdata[DIST_W-1:0]);
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/akt_norm.sv
module akt_norm #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 15
) (
    input  logic [SAMPLE_BITS-1:0]          top_level,
    input  logic [akt_pkg::GAIN_W-1:0]      travel_gain,
    input  logic [SAMPLE_BITS-1:0]          raw_sample,
    output logic signed [FRACTION_BITS+1:0] travel
);
    import akt_pkg::*;

    localparam int TRAVEL_W = FRACTION_BITS + 2;
    localparam int DIFF_W   = SAMPLE_BITS + 1;
    localparam int PROD_W   = DIFF_W + GAIN_W + 1;
    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'((1 << (TRAVEL_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [DIFF_W-1:0] diff;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] scaled;

    assign diff   = $signed({1'b0, top_level}) - $signed({1'b0, raw_sample});
    assign gain_s = $signed({1'b0, travel_gain});
    assign prod   = diff * gain_s;
    // arithmetic shift floors toward minus infinity
    assign scaled = prod >>> GAIN_SHIFT;

    always_comb begin
        if (scaled > SAT_MAX) begin
            travel = SAT_MAX[TRAVEL_W-1:0];
        end else if (scaled < SAT_MIN) begin
            travel = SAT_MIN[TRAVEL_W-1:0];
        end else begin
            travel = scaled[TRAVEL_W-1:0];
        end
    end

endmodule

### rtl/akt_core.sv
module akt_core #(
    parameter int FRACTION_BITS = 15
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  akt_pkg::akt_cfg_t               cfg,
    input  logic                            mid_valid,
    output logic                            mid_ready,
    input  akt_pkg::akt_item_t              mid_item,
    input  logic signed [FRACTION_BITS+1:0] mid_travel,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_key_pressed,
    output logic                            m_press_event,
    output logic                            m_release_event,
    output logic signed [FRACTION_BITS+1:0] m_travel
);
    import akt_pkg::*;

    localparam int TRAVEL_W = FRACTION_BITS + 2;
    localparam int CMP_W    = ((TRAVEL_W > DIST_W) ? TRAVEL_W : DIST_W) + 2;
    localparam logic signed [CMP_W-1:0] TRAVEL_ONE  = CMP_W'(1 << FRACTION_BITS);
    localparam logic signed [CMP_W-1:0] TRAVEL_ZERO = '0;

    logic                       pressed_reg, pressed_next;
    logic signed [TRAVEL_W-1:0] last_reg, last_next;
    logic signed [TRAVEL_W-1:0] min_reg, min_next;
    logic signed [TRAVEL_W-1:0] max_reg, max_next;

    logic                       valid_reg;
    logic                       key_reg;
    logic                       press_reg;
    logic                       release_reg;
    logic signed [TRAVEL_W-1:0] travel_reg;

    logic                       take;
    logic signed [CMP_W-1:0]    v_w, mn_w, mx_w, last_w, hyst_w, diff_w;
    logic signed [CMP_W-1:0]    trig_w, rel_w, tspd_w, rspd_w;
    logic                       st;

    assign mid_ready = !valid_reg || m_ready;
    assign take      = mid_valid && mid_ready;

    assign v_w    = CMP_W'(mid_travel);
    assign last_w = CMP_W'(last_reg);
    assign hyst_w = $signed(CMP_W'({1'b0, cfg.hysteresis}));
    assign trig_w = CMP_W'(cfg.press_dist);
    assign rel_w  = CMP_W'(cfg.lift_dist);
    assign tspd_w = CMP_W'(cfg.press_rate);
    assign rspd_w = CMP_W'(cfg.lift_rate);
    assign diff_w = v_w - last_w;

    always_comb begin
        st   = pressed_reg;
        mn_w = CMP_W'(min_reg);
        mx_w = CMP_W'(max_reg);
        last_next = last_reg;
        if (mid_item.req_type) begin
            st = mid_item.forced_state;
        end else begin
            case (cfg.key_mode)
                MODE_DIGITAL: begin
                    st = mid_item.raw_nonzero;
                end
                MODE_THRESH: begin
                    if (v_w - hyst_w > trig_w) st = 1'b1;
                    if (v_w + hyst_w < trig_w) st = 1'b0;
                    last_next = mid_travel;
                end
                MODE_RAPID: begin
                    if (pressed_reg) begin
                        if (v_w - mn_w >= trig_w && v_w > mx_w) mx_w = v_w;
                        if (mx_w - v_w >= rel_w) begin
                            mn_w = v_w;
                            st   = 1'b0;
                        end
                    end else begin
                        if (v_w - mn_w >= trig_w) begin
                            mx_w = v_w;
                            st   = 1'b1;
                        end
                        if (mx_w - v_w >= rel_w && v_w < mn_w) mn_w = v_w;
                    end
                    // clamps at rest and at full press
                    if (v_w <= TRAVEL_ZERO) begin
                        st   = 1'b0;
                        mn_w = '0;
                    end
                    if (v_w >= TRAVEL_ONE) begin
                        st   = 1'b1;
                        mx_w = TRAVEL_ONE;
                    end
                    last_next = mid_travel;
                end
                MODE_SPEED: begin
                    if (diff_w > tspd_w) st = 1'b1;
                    if (diff_w < rspd_w) st = 1'b0;
                    last_next = mid_travel;
                end
                default: begin
                end
            endcase
        end
        pressed_next = st;
        min_next     = min_reg;
        max_next     = max_reg;
        if (!mid_item.req_type && cfg.key_mode == MODE_RAPID) begin
            min_next = mn_w[TRAVEL_W-1:0];
            max_next = mx_w[TRAVEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg <= 1'b0;
            last_reg    <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (take) begin
                pressed_reg <= pressed_next;
                last_reg    <= last_next;
                min_reg     <= min_next;
                max_reg     <= max_next;
                valid_reg   <= 1'b1;
            end else if (m_ready) begin
                valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            key_reg     <= pressed_next;
            press_reg   <= !pressed_reg && pressed_next;
            release_reg <= pressed_reg && !pressed_next;
            travel_reg  <= last_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_key_pressed   = key_reg;
    assign m_press_event   = press_reg;
    assign m_release_event = release_reg;
    assign m_travel        = travel_reg;

endmodule

### rtl/analog_key_trigger_top.sv
// Analog key trigger: one raw position sample (or a forced state) in, one
// result out with key state, press/release pulses and Q15 travel.
// Input channel s_*: req_type selects a raw sample (0) or a forced state (1).
// Result channel m_*: exactly one result per input transaction, in order.
// Config channel cfg_*: register index and data, always ready; write only
// while no transaction is in flight.
// Path: the input register, then the normalize multiply into the middle
// register, then the mode logic into the output register. Throughput: one
// transaction per cycle while m_ready stays high; the key state is held in
// the final stage, so back-to-back samples see each other's updates.
// Reset: config returns to defaults, key released, travel/min/max cleared,
// pipeline emptied.
// Stalls: when m_ready is low the result holds and the pipeline fills; with
// all three stages full s_ready drops in the same cycle.
module analog_key_trigger_top #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 15
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [SAMPLE_BITS-1:0]            s_raw_sample,
    input  logic                              s_forced_state,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_key_pressed,
    output logic                              m_press_event,
    output logic                              m_release_event,
    output logic signed [FRACTION_BITS+1:0]   m_travel,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [akt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [akt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import akt_pkg::*;

    localparam int TRAVEL_W = FRACTION_BITS + 2;

    akt_cfg_t                   cfg;
    logic [SAMPLE_BITS-1:0]     top_level;

    logic                       in_valid_reg;
    logic                       in_req_reg;
    logic                       in_forced_reg;
    logic [SAMPLE_BITS-1:0]     in_raw_reg;

    logic                       mid_valid_reg;
    akt_item_t                  mid_item_reg;
    logic signed [TRAVEL_W-1:0] mid_travel_reg;

    logic                       mid_ready;
    logic                       in_adv;
    logic signed [TRAVEL_W-1:0] norm_travel;

    assign in_adv  = !mid_valid_reg || mid_ready;
    assign s_ready = !in_valid_reg || in_adv;

    akt_cfg #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .top_level (top_level)
    );

    akt_norm #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_norm (
        .top_level   (top_level),
        .travel_gain (cfg.travel_gain),
        .raw_sample  (in_raw_reg),
        .travel      (norm_travel)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (in_adv) mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg    <= s_req_type;
            in_forced_reg <= s_forced_state;
            in_raw_reg    <= s_raw_sample;
        end
        if (in_valid_reg && in_adv) begin
            mid_item_reg.req_type     <= in_req_reg;
            mid_item_reg.forced_state <= in_forced_reg;
            mid_item_reg.raw_nonzero  <= |in_raw_reg;
            mid_travel_reg            <= norm_travel;
        end
    end

    akt_core #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .mid_valid       (mid_valid_reg),
        .mid_ready       (mid_ready),
        .mid_item        (mid_item_reg),
        .mid_travel      (mid_travel_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_key_pressed   (m_key_pressed),
        .m_press_event   (m_press_event),
        .m_release_event (m_release_event),
        .m_travel        (m_travel)
    );

endmodule

### rtl/akt_checker.sv
module akt_checker #(
    parameter int FRACTION_BITS = 15
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_key_pressed,
    input logic                            m_press_event,
    input logic                            m_release_event,
    input logic signed [FRACTION_BITS+1:0] m_travel
);

    // reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_travel) && $stable(m_key_pressed))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_press_event && m_release_event))
        else $error("press and release in one transaction");

    // an edge pulse must agree with the state it reports
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_press_event || m_release_event) |-> m_key_pressed == m_press_event)
        else $error("edge pulse disagrees with key state");

endmodule

bind analog_key_trigger_top akt_checker #(
    .FRACTION_BITS(FRACTION_BITS)
) u_akt_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_key_pressed   (m_key_pressed),
    .m_press_event   (m_press_event),
    .m_release_event (m_release_event),
    .m_travel        (m_travel)
);

### tb/analog_key_trigger_top_tb.sv
`timescale 1ns / 100ps

module analog_key_trigger_top_tb;
    import akt_pkg::*;

    localparam longint TRAVEL_MAX  = 65535;
    localparam longint TRAVEL_MIN  = -65536;
    localparam longint TRAVEL_ONE  = 32768;
    localparam int     DRAIN_TAIL  = 6;
    localparam int     CYCLE_LIMIT = 500000;
    localparam int     PHASES      = 16;
    localparam int     PHASE_ITEMS = 97;

    typedef struct {
        logic               pressed;
        logic               press_ev;
        logic               release_ev;
        logic signed [16:0] travel;
    } key_report_t;

    // Tracks config and key state, predicts one report per accepted sample.
    class key_trigger_sb;
        key_mode_t          mode;
        logic [11:0]        top_level;
        logic [23:0]        gain;
        logic signed [16:0] trig_dist;
        logic signed [16:0] rel_dist;
        logic [15:0]        hyst;
        logic signed [16:0] trig_speed;
        logic signed [16:0] rel_speed;
        logic               key_down;
        logic signed [16:0] prev_travel;
        logic signed [16:0] travel_floor;
        logic signed [16:0] travel_peak;
        key_report_t        expected_reports[$];
        int                 errors;

        function new();
            mode         = MODE_DIGITAL;
            top_level    = 12'd4095;
            gain         = RST_TRAVEL_GAIN;
            trig_dist    = RST_PRESS_DIST;
            rel_dist     = RST_LIFT_DIST;
            hyst         = RST_HYSTERESIS;
            trig_speed   = RST_PRESS_RATE;
            rel_speed    = RST_LIFT_RATE;
            key_down     = 1'b0;
            prev_travel  = '0;
            travel_floor = '0;
            travel_peak  = '0;
            errors       = 0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void set_reg(cfg_idx_t idx, logic [23:0] data);
            case (idx)
                REG_KEY_MODE:    mode       = key_mode_t'(data[1:0]);
                REG_TOP_LEVEL:   top_level  = data[11:0];
                REG_TRAVEL_GAIN: gain       = data;
                REG_PRESS_DIST:  trig_dist  = data[16:0];
                REG_LIFT_DIST:   rel_dist   = data[16:0];
                REG_HYSTERESIS:  hyst       = data[15:0];
                REG_PRESS_RATE:  trig_speed = data[16:0];
                REG_LIFT_RATE:   rel_speed  = data[16:0];
                default: ;
            endcase
        endfunction

        // floor((top - raw) * gain / 2^16), saturated to 17-bit signed
        function longint travel_of(logic [11:0] raw);
            longint scaled;
            scaled = (longint'(top_level) - longint'(raw)) * longint'(gain);
            scaled = scaled >>> GAIN_SHIFT;
            if (scaled > TRAVEL_MAX) scaled = TRAVEL_MAX;
            if (scaled < TRAVEL_MIN) scaled = TRAVEL_MIN;
            return scaled;
        endfunction

        function void note_sample(logic req_type, logic [11:0] raw, logic forced);
            logic        was;
            logic        now;
            longint      pos, lo, hi, delta;
            longint      td, rd, hy, ts, rs;
            key_report_t rep;
            was = key_down;
            now = was;
            td  = trig_dist;
            rd  = rel_dist;
            hy  = hyst;
            ts  = trig_speed;
            rs  = rel_speed;
            if (req_type) begin
                now = forced;
            end else if (mode == MODE_DIGITAL) begin
                now = (raw != 0);
            end else begin
                pos = travel_of(raw);
                lo  = travel_floor;
                hi  = travel_peak;
                case (mode)
                    MODE_THRESH: begin
                        if (pos - hy > td) now = 1'b1;
                        if (pos + hy < td) now = 1'b0;
                    end
                    MODE_RAPID: begin
                        if (was) begin
                            if (pos - lo >= td && pos > hi) hi = pos;
                            if (hi - pos >= rd) begin
                                lo  = pos;
                                now = 1'b0;
                            end
                        end else begin
                            if (pos - lo >= td) begin
                                hi  = pos;
                                now = 1'b1;
                            end
                            if (hi - pos >= rd && pos < lo) lo = pos;
                        end
                        // clamps at rest and at full press
                        if (pos <= 0) begin
                            now = 1'b0;
                            lo  = 0;
                        end
                        if (pos >= TRAVEL_ONE) begin
                            now = 1'b1;
                            hi  = TRAVEL_ONE;
                        end
                        travel_floor = lo[16:0];
                        travel_peak  = hi[16:0];
                    end
                    default: begin
                        delta = pos - longint'(prev_travel);
                        if (delta > ts) now = 1'b1;
                        if (delta < rs) now = 1'b0;
                    end
                endcase
                prev_travel = pos[16:0];
            end
            key_down       = now;
            rep.pressed    = now;
            rep.press_ev   = !was && now;
            rep.release_ev = was && !now;
            rep.travel     = prev_travel;
            expected_reports.push_back(rep);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_report(logic pressed, logic press_ev, logic release_ev,
                                   logic signed [16:0] travel);
            key_report_t want;
            if (expected_reports.size() == 0) begin
                flag($sformatf("unexpected result pressed=%0b press=%0b release=%0b travel=%0d",
                               pressed, press_ev, release_ev, travel));
                return;
            end
            want = expected_reports.pop_front();
            if (want.pressed !== pressed || want.press_ev !== press_ev ||
                    want.release_ev !== release_ev || want.travel !== travel) begin
                flag($sformatf("expected %0b/%0b/%0b travel=%0d, got %0b/%0b/%0b travel=%0d",
                               want.pressed, want.press_ev, want.release_ev, want.travel,
                               pressed, press_ev, release_ev, travel));
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_req_type = 1'b0;
    logic [11:0]        s_raw_sample = '0;
    logic               s_forced_state = 1'b0;
    logic               m_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [23:0]        cfg_wdata = '0;
    logic               s_ready;
    logic               m_valid;
    logic               m_key_pressed;
    logic               m_press_event;
    logic               m_release_event;
    logic signed [16:0] m_travel;
    logic               cfg_ready;

    key_trigger_sb sb;
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            walk_pos, walk_goal, walk_rate, walk_lo, walk_hi;
    int unsigned   cycle_count = 0;
    key_mode_t     mode_order[4] = '{MODE_DIGITAL, MODE_THRESH, MODE_RAPID, MODE_SPEED};

    analog_key_trigger_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_raw_sample    (s_raw_sample),
        .s_forced_state  (s_forced_state),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_key_pressed   (m_key_pressed),
        .m_press_event   (m_press_event),
        .m_release_event (m_release_event),
        .m_travel        (m_travel),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[analog_key_trigger_top] ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_reg(cfg_idx_t'(cfg_index), cfg_wdata);
            if (s_valid && s_ready) sb.note_sample(s_req_type, s_raw_sample, s_forced_state);
            if (m_valid && m_ready) begin
                sb.check_report(m_key_pressed, m_press_event, m_release_event, m_travel);
            end
        end
    end

    task automatic send_sample(logic req_type, logic [11:0] raw, logic forced);
        @(negedge aclk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req_type;
        s_raw_sample   <= raw;
        s_forced_state <= forced;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic hold_samples();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [23:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(key_mode_t mode, int top, int gain, int td, int rd, int hy,
                             int ts, int rs);
        write_reg(REG_KEY_MODE, 24'(mode));
        write_reg(REG_TOP_LEVEL, 24'(top));
        write_reg(REG_TRAVEL_GAIN, 24'(gain));
        write_reg(REG_PRESS_DIST, 24'(td));
        write_reg(REG_LIFT_DIST, 24'(rd));
        write_reg(REG_HYSTERESIS, 24'(hy));
        write_reg(REG_PRESS_RATE, 24'(ts));
        write_reg(REG_LIFT_RATE, 24'(rs));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_edge(int lo, int hi);
        case ($urandom_range(2))
            0: return lo;
            1: return hi;
            default: return lo + int'($urandom_range(hi - lo));
        endcase
    endfunction

    // Mostly smooth strokes with reversals; the rest is forced state and noise.
    task automatic random_sample();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            send_sample(1'b1, 12'($urandom_range(4095)), 1'($urandom_range(1)));
        end else if (r < 12) begin
            send_sample(1'b0, 12'd0, 1'($urandom_range(1)));
        end else if (r < 16) begin
            send_sample(1'b0, 12'd4095, 1'($urandom_range(1)));
        end else if (r < 26) begin
            send_sample(1'b0, 12'($urandom_range(4095)), 1'($urandom_range(1)));
        end else begin
            if (walk_pos == walk_goal || $urandom_range(99) < 3) begin
                walk_goal = walk_lo + int'($urandom_range(walk_hi - walk_lo));
                walk_rate = $urandom_range(250, 1);
            end
            if (walk_goal > walk_pos)
                walk_pos = (walk_pos + walk_rate > walk_goal) ? walk_goal : walk_pos + walk_rate;
            else
                walk_pos = (walk_pos - walk_rate < walk_goal) ? walk_goal : walk_pos - walk_rate;
            send_sample(1'b0, 12'(walk_pos), 1'($urandom_range(1)));
        end
    endtask

    task automatic run_phase(int p);
        int        top, span;
        key_mode_t mode;
        mode = mode_order[p % 4];
        case (p / 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 48; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 48; end
            default: begin idle_pct = 14; stall_pct = 14; end
        endcase
        walk_lo = 0;
        walk_hi = 4095;
        case (p)
            6: configure(mode, 0, 0, -65536, -65536, 0, -65536, -65536);
            11: configure(mode, 4095, 16777215, 65535, 65535, 65535, 65535, 65535);
            15: configure(mode, pick_edge(0, 4095), pick_edge(0, 16777215),
                          pick_edge(-65536, 65535), pick_edge(-65536, 65535),
                          pick_edge(0, 65535), pick_edge(-65536, 65535),
                          pick_edge(-65536, 65535));
            default: begin
                top  = $urandom_range(4095, 1200);
                span = 200 + int'($urandom_range(top - 200));
                configure(mode, top, int'((64'd1 << 31) / span),
                          $urandom_range(24000, 200), $urandom_range(16000, 200),
                          $urandom_range(4000), int'($urandom_range(6000)) - 1000,
                          1000 - int'($urandom_range(6000)));
                // strokes run a little past both ends of the travel range
                walk_lo = (top - span - span / 8 < 0) ? 0 : top - span - span / 8;
                walk_hi = (top + span / 8 > 4095) ? 4095 : top + span / 8;
            end
        endcase
        walk_pos  = walk_hi;
        walk_goal = walk_hi;
        walk_rate = 1;
        repeat (PHASE_ITEMS) random_sample();
        hold_samples();
        drain();
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // digital mode from reset defaults, then forced state
        send_sample(1'b0, 12'd0, 1'b0);
        send_sample(1'b0, 12'd4095, 1'b0);
        send_sample(1'b0, 12'd1, 1'b0);
        send_sample(1'b0, 12'd0, 1'b1);
        send_sample(1'b1, 12'd0, 1'b1);
        send_sample(1'b1, 12'd4095, 1'b1);
        send_sample(1'b1, 12'd4095, 1'b0);
        hold_samples();
        drain();

        // threshold band: below, inside, above, inside, below, above
        configure(MODE_THRESH, 3000, 1073742, 16384, 3277, 1638, 1638, -1638);
        send_sample(1'b0, 12'd3000, 1'b0);
        send_sample(1'b0, 12'd2000, 1'b0);
        send_sample(1'b0, 12'd1500, 1'b0);
        send_sample(1'b0, 12'd2000, 1'b0);
        send_sample(1'b0, 12'd3000, 1'b0);
        send_sample(1'b0, 12'd0, 1'b0);
        hold_samples();
        drain();

        // rapid trigger: rest clamp, full press clamp, small lift, release, small rise
        configure(MODE_RAPID, 3000, 1073742, 16384, 3277, 1638, 1638, -1638);
        send_sample(1'b0, 12'd4095, 1'b0);
        send_sample(1'b0, 12'd1000, 1'b0);
        send_sample(1'b0, 12'd1100, 1'b0);
        send_sample(1'b0, 12'd1300, 1'b0);
        send_sample(1'b0, 12'd1200, 1'b0);
        hold_samples();
        drain();

        // speed mode with overlapping tests and saturated travel at both ends
        configure(MODE_SPEED, 4095, 16777215, 16384, 3277, 0, -1000, 1000);
        send_sample(1'b0, 12'd0, 1'b0);
        send_sample(1'b0, 12'd0, 1'b0);
        hold_samples();
        drain();
        configure(MODE_SPEED, 0, 16777215, 16384, 3277, 0, -1000, 1000);
        send_sample(1'b0, 12'd4095, 1'b0);
        hold_samples();
        drain();

        for (int p = 0; p < PHASES; p++) run_phase(p);

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[analog_key_trigger_top] OK");
        else
            $display("[analog_key_trigger_top] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/akt_pkg.sv
rtl/akt_cfg.sv
rtl/akt_norm.sv
rtl/akt_core.sv
rtl/analog_key_trigger_top.sv
rtl/akt_checker.sv
tb/analog_key_trigger_top_tb.sv
